@@ rtl/pdnr_pkg.sv @@
// Shared types and constants for the PPPoE downstream NAT rewrite block.
package pdnr_pkg;

  localparam int unsigned IndexBitsDef = 16;

  localparam int unsigned InDataW  = 152;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned CfgDataW = 48;

  localparam logic [15:0] EtPppoeDisc = 16'h8863;
  localparam logic [15:0] EtPppoeSess = 16'h8864;
  localparam logic [15:0] PppLcp      = 16'hC021;
  localparam logic [15:0] PppIpcp     = 16'h8021;
  localparam logic [15:0] AuthResetVal = 16'hC023;
  localparam logic [7:0]  IppIcmp     = 8'd1;
  localparam logic [7:0]  IppTcp      = 8'd6;
  localparam logic [7:0]  IppUdp      = 8'd17;
  localparam logic [3:0]  AliveValue  = 4'd10;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_DROP  = 3'd0,
    ACT_CTRL  = 3'd1,
    ACT_ICMP  = 3'd2,
    ACT_UDP   = 3'd3,
    ACT_TCP   = 3'd4,
    ACT_TABLE = 3'd5
  } act_t;

  typedef enum logic [0:0] {
    CFG_LAN_MAC  = 1'b0,
    CFG_AUTH     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } st_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] port;
  } nat_entry_t;

  // Table control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_entry_en;
    logic wr_alive_en;
  } tbl_ctl_t;

endpackage

@@ rtl/pdnr_table.sv @@
// NAT entry memory and alive-mark memory with post-reset clearing sweep.
module pdnr_table #(
  parameter int unsigned INDEX_BITS = pdnr_pkg::IndexBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pdnr_pkg::tbl_ctl_t     ctl,
  input  logic [INDEX_BITS-1:0]  rd_addr,
  input  logic [INDEX_BITS-1:0]  wr_addr,
  input  pdnr_pkg::nat_entry_t   wr_entry,
  output pdnr_pkg::nat_entry_t   rd_entry,
  output logic                   rd_alive,
  output logic                   clear_done
);
  import pdnr_pkg::*;

  localparam int unsigned Depth = 2 ** INDEX_BITS;

  nat_entry_t entry_mem [Depth];
  // Alive marks only ever hold zero or the keep-alive value: one bit each.
  logic       alive_mem [Depth];

  logic [INDEX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                  clr_busy_r, clr_busy_nxt;

  logic                  alive_we;
  logic [INDEX_BITS-1:0] alive_waddr;
  logic                  alive_wbit;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r + 1'b1;
    clr_busy_nxt = clr_busy_r && (clr_cnt_r != {INDEX_BITS{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  assign clear_done = !clr_busy_r;

  always_comb begin
    if (clr_busy_r) begin
      alive_we    = 1'b1;
      alive_waddr = clr_cnt_r;
      alive_wbit  = 1'b0;
    end else begin
      alive_we    = ctl.wr_alive_en;
      alive_waddr = wr_addr;
      alive_wbit  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_entry_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (alive_we) begin
      alive_mem[alive_waddr] <= alive_wbit;
    end
    if (ctl.rd_en) begin
      rd_alive <= alive_mem[rd_addr];
    end
  end

endmodule

@@ rtl/pppoe_downstream_nat_rewrite.sv @@
// PPPoE downstream decapsulation with reverse NAT lookup: top level.
//
// Input words carry a received frame's header fields, a NAT entry write or a
// NAT entry read; the command sits in in_tuser. Every accepted word yields
// exactly one output word whose action code sits in out_tuser.
// Forwarded frames (ICMP, UDP, TCP over a PPPoE session) are rewritten to the
// stored LAN MAC, IP and port, with lan_mac as source, and mark the entry alive.
// The accept edge issues the table read; in the lookup stage the registered
// read data is used, the entry or alive mark is written back and the output
// register is loaded once it is free. A new word is accepted only after the
// last one has left the lookup stage, set by the single read-modify-write pass
// through the table memories. After reset the alive-mark memory is swept
// to zero, one entry per cycle, with in_tready low until the sweep ends.
// Config writes are taken during the sweep.
// A word can be accepted while the previous result waits in the output
// register; if out_tready stays low the block holds the second result in its
// lookup stage and stops accepting until the output register frees.
module pppoe_downstream_nat_rewrite #(
  parameter int unsigned INDEX_BITS = pdnr_pkg::IndexBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // frame type, session protocol, L4 protocol, lookup_key, entry_mac,
  // entry_ip, entry_port
  input  logic [pdnr_pkg::InDataW-1:0]   in_tdata,
  // command
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // new_dst_mac, new_src_mac, new_dst_ip, new_port, alive_mark, zero pad
  output logic [pdnr_pkg::OutDataW-1:0]  out_tdata,
  // action
  output logic [2:0]                     out_tuser,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_addr,
  input  logic [pdnr_pkg::CfgDataW-1:0]  cfg_wdata
);
  import pdnr_pkg::*;

  // config registers
  logic [47:0] lan_mac_r;
  logic [15:0] auth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lan_mac_r <= '0;
      auth_r    <= AuthResetVal;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LAN_MAC: lan_mac_r <= cfg_wdata;
        CFG_AUTH:    auth_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input field unpack
  logic                  in_acc;
  logic [INDEX_BITS-1:0] in_idx;

  assign in_acc = in_tvalid && in_tready;
  assign in_idx = in_tdata[40 +: INDEX_BITS];

  // held item
  cmd_t                  cmd_r;
  logic [15:0]           etype_r;
  logic [15:0]           pproto_r;
  logic [7:0]            iproto_r;
  logic [INDEX_BITS-1:0] idx_r;
  nat_entry_t            wentry_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r         <= cmd_t'(in_tuser);
      etype_r       <= in_tdata[15:0];
      pproto_r      <= in_tdata[31:16];
      iproto_r      <= in_tdata[39:32];
      idx_r         <= in_idx;
      wentry_r.mac  <= in_tdata[103:56];
      wentry_r.ip   <= in_tdata[135:104];
      wentry_r.port <= in_tdata[151:136];
    end
  end

  // table
  tbl_ctl_t   tbl_ctl;
  nat_entry_t rd_entry;
  logic       rd_alive;
  logic       clear_done;

  pdnr_table #(
    .INDEX_BITS(INDEX_BITS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .rd_addr    (in_idx),
    .wr_addr    (idx_r),
    .wr_entry   (wentry_r),
    .rd_entry   (rd_entry),
    .rd_alive   (rd_alive),
    .clear_done (clear_done)
  );

  // sequencer
  st_t  state_r, state_nxt;
  logic out_valid_r;
  logic out_free;
  logic look_done;

  assign out_free  = !out_valid_r || out_tready;
  assign look_done = (state_r == ST_LOOK) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid)  state_nxt = ST_LOOK;
      ST_LOOK:  if (out_free)   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result of the held item
  act_t        act_nxt;
  logic [47:0] dmac_nxt;
  logic [47:0] smac_nxt;
  logic [31:0] dip_nxt;
  logic [15:0] port_nxt;
  logic [3:0]  alive_nxt;
  logic [3:0]  stored_alive;
  logic        is_ctrl;

  assign stored_alive = rd_alive ? AliveValue : 4'd0;
  assign is_ctrl = (etype_r == EtPppoeDisc) || (pproto_r == PppLcp) ||
                   (pproto_r == auth_r) || (pproto_r == PppIpcp);

  always_comb begin
    act_nxt   = ACT_DROP;
    dmac_nxt  = '0;
    smac_nxt  = '0;
    dip_nxt   = '0;
    port_nxt  = '0;
    alive_nxt = '0;
    case (cmd_r)
      CMD_WRITE: begin
        act_nxt   = ACT_TABLE;
        dmac_nxt  = wentry_r.mac;
        dip_nxt   = wentry_r.ip;
        port_nxt  = wentry_r.port;
        alive_nxt = stored_alive;
      end
      CMD_READ: begin
        act_nxt   = ACT_TABLE;
        dmac_nxt  = rd_entry.mac;
        dip_nxt   = rd_entry.ip;
        port_nxt  = rd_entry.port;
        alive_nxt = stored_alive;
      end
      CMD_FRAME: begin
        if (etype_r != EtPppoeDisc && etype_r != EtPppoeSess) begin
          act_nxt = ACT_DROP;
        end else if (is_ctrl) begin
          act_nxt = ACT_CTRL;
        end else begin
          case (iproto_r)
            IppIcmp: act_nxt = ACT_ICMP;
            IppUdp:  act_nxt = ACT_UDP;
            IppTcp:  act_nxt = ACT_TCP;
            default: act_nxt = ACT_DROP;
          endcase
          if (act_nxt != ACT_DROP) begin
            dmac_nxt  = rd_entry.mac;
            smac_nxt  = lan_mac_r;
            dip_nxt   = rd_entry.ip;
            port_nxt  = rd_entry.port;
            alive_nxt = AliveValue;
          end
        end
      end
      default: act_nxt = ACT_DROP;
    endcase
  end

  // table control outputs
  always_comb begin
    in_tready           = (state_r == ST_IDLE);
    tbl_ctl.rd_en       = in_acc;
    tbl_ctl.wr_entry_en = look_done && (cmd_r == CMD_WRITE);
    tbl_ctl.wr_alive_en = look_done && (cmd_r == CMD_FRAME) &&
                          (act_nxt == ACT_ICMP || act_nxt == ACT_UDP ||
                           act_nxt == ACT_TCP);
  end

  // output register
  act_t        out_act_r;
  logic [47:0] out_dmac_r;
  logic [47:0] out_smac_r;
  logic [31:0] out_dip_r;
  logic [15:0] out_port_r;
  logic [3:0]  out_alive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (look_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      out_act_r   <= act_nxt;
      out_dmac_r  <= dmac_nxt;
      out_smac_r  <= smac_nxt;
      out_dip_r   <= dip_nxt;
      out_port_r  <= port_nxt;
      out_alive_r <= alive_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {4'd0, out_alive_r, out_port_r, out_dip_r, out_smac_r, out_dmac_r};

  // checks
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOK))
    else $error("accepted word did not enter lookup");

  a_entry_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.wr_entry_en |-> (cmd_r == CMD_WRITE) && (state_r == ST_LOOK))
    else $error("entry write outside a table write");

  a_alive_write_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.wr_alive_en |-> (act_nxt == ACT_ICMP || act_nxt == ACT_UDP ||
                             act_nxt == ACT_TCP) && clear_done)
    else $error("alive mark set without forwarding");

  a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result appeared without a lookup");

endmodule
